/* hdl/lpkv_pkg.sv */
package lpkv_pkg;

	localparam int SLOTS_DEF  = 64;
	localparam int KEY_W      = 64;
	localparam int VAL_W      = 64;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;
	localparam int HOME_SHIFT = 2;
	localparam int HASH_BITS  = KEY_W - HOME_SHIFT;

	localparam logic [OP_W-1:0] OP_GET    = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [VAL_W-1:0]    old_value;
		logic [COUNT_W-1:0]  pair_count;
	} rsp_t;

endpackage

/* hdl/lpkv_ram.sv */
module lpkv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/lpkv_home.sv */
module lpkv_home
	import lpkv_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [KEY_W-1:0]         key,
	output logic                     done,
	output logic [$clog2(SLOTS)-1:0] home
);

	localparam int IDXW = $clog2(SLOTS);
	localparam bit POW2 = (SLOTS == (1 << IDXW));

	logic [IDXW-1:0] rem_q;
	logic            done_q;

	generate
		if (POW2) begin : g_mask
			// power-of-two table: the remainder is the low index bits
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= key[HOME_SHIFT +: IDXW];
				end
			end
		end else begin : g_fold
			localparam int CHUNK  = 16;
			localparam int SUM_W  = CHUNK + 2 + IDXW;
			localparam int QUO_W  = SUM_W - IDXW + 1;
			localparam int SHIFT  = SUM_W + IDXW;
			localparam int PROD_W = 2 * SUM_W + 1;
			localparam logic [SUM_W-1:0] WT1 = SUM_W'((64'd1 << CHUNK) % SLOTS);
			localparam logic [SUM_W-1:0] WT2 = SUM_W'((64'd1 << (2 * CHUNK)) % SLOTS);
			localparam logic [SUM_W-1:0] WT3 = SUM_W'((64'd1 << (3 * CHUNK)) % SLOTS);
			localparam logic [SUM_W:0]   RECIP =
				(SUM_W + 1)'(((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

			logic [HASH_BITS-1:0] hv;
			logic [SUM_W-1:0]     fold;
			logic [PROD_W-1:0]    prod;
			logic [SUM_W-1:0]     rem_full;
			logic [SUM_W-1:0]     sum_s1;
			logic                 vld_s1;
			logic [SUM_W-1:0]     sum_s2;
			logic [QUO_W-1:0]     quo_s2;
			logic                 vld_s2;

			// fold the chunks by their weights mod SLOTS, then reduce by reciprocal multiply
			assign hv   = key[KEY_W-1:HOME_SHIFT];
			assign fold = SUM_W'(hv[CHUNK-1:0])
				+ SUM_W'(hv[2*CHUNK-1:CHUNK]) * WT1
				+ SUM_W'(hv[3*CHUNK-1:2*CHUNK]) * WT2
				+ SUM_W'(hv[HASH_BITS-1:3*CHUNK]) * WT3;
			assign prod     = PROD_W'(sum_s1) * PROD_W'(RECIP);
			assign rem_full = sum_s2 - SUM_W'(quo_s2) * SUM_W'(SLOTS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1 <= 1'b0;
					vld_s2 <= 1'b0;
					done_q <= 1'b0;
				end else begin
					vld_s1 <= start;
					vld_s2 <= vld_s1;
					done_q <= vld_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sum_s1 <= fold;
				end
				if (vld_s1) begin
					sum_s2 <= sum_s1;
					quo_s2 <= prod[SHIFT +: QUO_W];
				end
				if (vld_s2) begin
					rem_q <= rem_full[IDXW-1:0];
				end
			end
		end
	endgenerate

	assign done = done_q;
	assign home = rem_q;

endmodule

/* hdl/linear_probe_key_value_table.sv */
// Key/value table of SLOTS entries with open addressing and linear probing; key zero
// marks an empty slot and is rejected. One item is in work at a time. After reset a
// clearing pass writes every key slot to zero, with req_ready low. An item passes through
// these steps: accept, the home-slot reduction (the low index bits when SLOTS is a power
// of two, else chunk folding and reciprocal multiplication), the scan (one key-memory
// read a cycle from home with wrap, ending at a matching key or after every slot is
// read), one commit and the load of the result register, which waits while the
// previous result item is not yet taken. A zero key skips reduction and scan.
module linear_probe_key_value_table
	import lpkv_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IDXW = $clog2(SLOTS);
	localparam int CNTW = $clog2(SLOTS + 1);
	localparam logic [CNTW-1:0] SLOTS_N  = CNTW'(SLOTS);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_HASH   = 6'b000100,
		S_SCAN   = 6'b001000,
		S_COMMIT = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t          state_q;
	logic [OP_W-1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic            zero_q;
	logic [IDXW-1:0] clr_addr_q;
	logic [IDXW-1:0] rd_addr_q;
	logic [CNTW-1:0] issue_cnt_q;
	logic            rd_vld_s1;
	logic [IDXW-1:0] rd_idx_s1;
	logic            hit_q;
	logic [IDXW-1:0] hit_idx_q;
	logic            empty_q;
	logic [IDXW-1:0] empty_idx_q;
	logic [VAL_W-1:0] old_q;
	logic [CNTW-1:0] cnt_q;
	rsp_t            res_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	logic            accept;
	logic            home_done;
	logic [IDXW-1:0] home_idx;
	logic [KEY_W-1:0] key_rdata;
	logic [VAL_W-1:0] val_rdata;
	logic            match;
	logic            issue;
	logic            is_put;
	logic            is_remove;
	logic            do_insert;
	logic            do_delete;
	logic            do_update;
	logic            key_we;
	logic [IDXW-1:0] key_waddr;
	logic [KEY_W-1:0] key_wdata;
	logic            val_we;
	logic [IDXW-1:0] val_waddr;
	logic [CNTW-1:0] cnt_next;
	logic [STATUS_W-1:0] status_next;
	logic            rsp_load;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	lpkv_home #(.SLOTS(SLOTS)) u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (req.key != '0)),
		.key    (req.key),
		.done   (home_done),
		.home   (home_idx)
	);

	lpkv_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (rd_addr_q),
		.rdata (key_rdata)
	);

	lpkv_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.raddr (rd_addr_q),
		.rdata (val_rdata)
	);

	// scan: compare last cycle's read, issue the next until a key matches or all slots are read
	assign match = rd_vld_s1 && (key_rdata == key_q);
	assign issue = (state_q == S_SCAN) && (issue_cnt_q != SLOTS_N) && !match;

	assign is_put    = (op_q == OP_PUT);
	assign is_remove = (op_q == OP_REMOVE);
	assign do_update = !zero_q && is_put && hit_q;
	assign do_insert = !zero_q && is_put && !hit_q && empty_q;
	assign do_delete = !zero_q && is_remove && hit_q;

	always_comb begin
		key_we    = 1'b0;
		key_waddr = clr_addr_q;
		key_wdata = '0;
		if (state_q == S_CLEAR) begin
			key_we = 1'b1;
		end else if (state_q == S_COMMIT) begin
			if (do_insert) begin
				key_we    = 1'b1;
				key_waddr = empty_idx_q;
				key_wdata = key_q;
			end else if (do_delete) begin
				key_we    = 1'b1;
				key_waddr = hit_idx_q;
			end
		end
	end

	assign val_we    = (state_q == S_COMMIT) && (do_update || do_insert);
	assign val_waddr = hit_q ? hit_idx_q : empty_idx_q;

	always_comb begin
		cnt_next = cnt_q;
		if (do_insert) begin
			cnt_next = cnt_q + 1'b1;
		end else if (do_delete) begin
			cnt_next = cnt_q - 1'b1;
		end
	end

	always_comb begin
		if (zero_q) begin
			status_next = ST_ZERO_KEY;
		end else if (is_put) begin
			status_next = (hit_q || empty_q) ? ST_OK : ST_FULL;
		end else begin
			status_next = hit_q ? ST_OK : ST_NOT_FOUND;
		end
	end

	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			issue_cnt_q <= '0;
			hit_q       <= 1'b0;
			empty_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			// a new result item replaces one taken in the same cycle
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						hit_q   <= 1'b0;
						empty_q <= 1'b0;
						state_q <= (req.key == '0) ? S_COMMIT : S_HASH;
					end
				end
				S_HASH: begin
					issue_cnt_q <= '0;
					if (home_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_COMMIT;
					end else if (rd_vld_s1) begin
						if (key_rdata == '0 && !empty_q) begin
							empty_q <= 1'b1;
						end
					end else if (issue_cnt_q == SLOTS_N) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					cnt_q   <= cnt_next;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.opcode;
			key_q  <= req.key;
			val_q  <= req.value;
			zero_q <= (req.key == '0);
			old_q  <= '0;
		end
		rd_idx_s1 <= rd_addr_q;
		if (state_q == S_HASH) begin
			rd_addr_q <= home_idx;
		end else if (issue) begin
			rd_addr_q <= (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1;
		end
		if (state_q == S_SCAN && match) begin
			hit_idx_q <= rd_idx_s1;
			old_q     <= val_rdata;
		end
		if (state_q == S_SCAN && rd_vld_s1 && !match && key_rdata == '0 && !empty_q) begin
			empty_idx_q <= rd_idx_s1;
		end
		if (state_q == S_COMMIT) begin
			res_q.status     <= status_next;
			res_q.found      <= hit_q;
			res_q.old_value  <= old_q;
			res_q.pair_count <= COUNT_W'(cnt_next);
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOTS_N)
		else $error("pair count beyond table size");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_cnt_q <= SLOTS_N)
		else $error("scan read more slots than the table holds");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && res_q.status == ST_FULL |-> cnt_q == SLOTS_N)
		else $error("table full reported with free slots");

	a_found_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && res_q.found |-> res_q.status == ST_OK)
		else $error("found key reported with error status");

	a_key_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		key_we && key_wdata != '0 |-> state_q == S_COMMIT && is_put && !hit_q)
		else $error("nonzero key written outside an insert");

endmodule
